/* hw/rtl/fm_sound_timer_status_regs_core_macros.svh */
// ----------------------------------------------------------------------------
// FM sound timer/status registers - assertion macros
// Concurrent assertion helpers shared by the RTL, clocked on clk and
// disabled during rst.
// ----------------------------------------------------------------------------
`ifndef FM_SOUND_TIMER_STATUS_REGS_CORE_MACROS_SVH
`define FM_SOUND_TIMER_STATUS_REGS_CORE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define FSTR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fstr assertion failed");

// next-cycle implication
`define FSTR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fstr assertion failed");

`else

`define FSTR_ASSERT_NOW(lbl, ante, cons)
`define FSTR_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* hw/rtl/fstr_pkg.sv */
// ----------------------------------------------------------------------------
// fstr_pkg - shared types and constants
// Action codes, register numbers, widths and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package fstr_pkg;

  // microsecond clock width (32..64)
  localparam int TIME_BITS = 64;
  typedef logic [TIME_BITS-1:0] time_t;

  // field widths
  localparam int ACT_W     = 3;
  localparam int BYTE_W    = 8;
  localparam int ELAPSED_W = 32;
  localparam int REG_W     = 9;
  localparam int RATE_W    = 20;

  // divide: (ticks * 1e6) fits in 28 bits, ticks up to 256
  localparam int DIVIDEND_W = 28;
  localparam int TICKS_W    = 9;
  localparam int PROD_W     = TICKS_W + RATE_W;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);
  localparam logic [RATE_W-1:0]  US_PER_SEC = RATE_W'(1000000);
  localparam logic [TICKS_W-1:0] TICK_BASE  = TICKS_W'(9'h100);

  // stream widths
  localparam int S_TDATA_W = 40;
  localparam int S_TUSER_W = ACT_W;
  localparam int M_TDATA_W = 32;
  localparam int M_TUSER_W = 1;

  // config port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [RATE_W-1:0] RATE_ONE_RST = RATE_W'(12500);
  localparam logic [RATE_W-1:0] RATE_TWO_RST = RATE_W'(3125);

  // host port actions
  typedef enum logic [ACT_W-1:0] {
    ACT_ADDR    = 3'd0,
    ACT_ADDR_HI = 3'd1,
    ACT_DATA    = 3'd2,
    ACT_STATUS  = 3'd3,
    ACT_READ_HI = 3'd4
  } fstr_act_t;

  // register numbers (low byte of the address latch)
  localparam logic [BYTE_W-1:0] REG_TIMER_ONE  = 8'h02;
  localparam logic [BYTE_W-1:0] REG_TIMER_TWO  = 8'h03;
  localparam logic [BYTE_W-1:0] REG_TIMER_CTRL = 8'h04;
  localparam logic [REG_W-1:0]  BANK_HI        = 9'h100;

  // timer control bits
  localparam int CTL_STOP_BIT     = 7;
  localparam int CTL_MASK_ONE_BIT = 6;
  localparam int CTL_MASK_TWO_BIT = 5;
  localparam int CTL_EN_ONE_BIT   = 0;
  localparam int CTL_EN_TWO_BIT   = 1;

  // status byte
  localparam logic [BYTE_W-1:0] STAT_ANY   = 8'h80;
  localparam logic [BYTE_W-1:0] STAT_ONE   = 8'h40;
  localparam logic [BYTE_W-1:0] STAT_TWO   = 8'h20;
  localparam logic [BYTE_W-1:0] READ_HI_VAL = 8'hff;

  // controller -> datapath commands
  typedef struct packed {
    logic load;       // capture input item
    logic adv;        // advance clock
    logic apply;      // decode action, update state, stage result
    logic pick;       // select next timer to rearm
    logic mul;        // ticks * 1e6
    logic div_start;  // launch divider
    logic finish;     // write expiry
    logic emit;       // load output register
  } fstr_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic arm_pend;
    logic div_busy;
    logic out_busy;
  } fstr_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/fm_sound_timer_status_regs_core.sv */
// ----------------------------------------------------------------------------
// fm_sound_timer_status_regs_core - FM sound chip timer/status port
// Host port access handling: address latch, two interval timers with
// status readback, forwarding of other data writes; rate registers.
// ----------------------------------------------------------------------------
//  port    dir  fields (low bit up)
//  s_*     in   tuser: action[2:0]; tdata: port_data[7:0], elapsed_us[39:8]
//  m_*     out  tuser: forward_valid[0]; tdata: read_data[7:0],
//               forward_register[16:8], forward_value[24:17]
//  APB     in   0x0 timer_one_rate, 0x4 timer_two_rate (20 bits)
//
//  An item without a timer rearm passes advance, apply, select and emit.
//  Each rearm adds multiply, start and one-bit-per-cycle divide steps
//  (28 quotient bits); a timer control write may rearm both timers.
//  One item is in flight at a time; a result waiting in the output
//  register does not block the next accept, only the next hand-off.
//  rst is synchronous; all timer state and the clock clear to zero.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fm_sound_timer_status_regs_core_macros.svh"

module fm_sound_timer_status_regs_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // item input
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [fstr_pkg::S_TDATA_W-1:0]  s_tdata,  // port_data, elapsed_us
  input  wire logic [fstr_pkg::S_TUSER_W-1:0]  s_tuser,  // action
  // result output
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [fstr_pkg::M_TDATA_W-1:0]       m_tdata,  // read_data, fwd reg, fwd value
  output logic [fstr_pkg::M_TUSER_W-1:0]       m_tuser,  // forward_valid
  // configuration
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [fstr_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [fstr_pkg::PDATA_W-1:0]    pwdata,
  output logic [fstr_pkg::PDATA_W-1:0]         prdata,
  output logic                                 pready
);

  logic [fstr_pkg::RATE_W-1:0] rate_one;
  logic [fstr_pkg::RATE_W-1:0] rate_two;
  logic                        cfg_wr;
  fstr_pkg::fstr_cmd_t         cmd;
  fstr_pkg::fstr_stat_t        stat;

  // rate registers, decoded on the register-select address bit
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_one <= fstr_pkg::RATE_ONE_RST;
      rate_two <= fstr_pkg::RATE_TWO_RST;
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        rate_two <= pwdata[fstr_pkg::RATE_W-1:0];
      end else begin
        rate_one <= pwdata[fstr_pkg::RATE_W-1:0];
      end
    end
  end

  assign prdata = fstr_pkg::PDATA_W'(paddr[2] ? rate_two : rate_one);

  fstr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fstr_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .rate_one (rate_one),
    .rate_two (rate_two),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // checks
  `FSTR_ASSERT_NOW(a_no_accept_while_dividing, stat.div_busy, !s_tready)
  `FSTR_ASSERT_NOW(a_emit_into_free_slot, cmd.emit, !stat.out_busy)
  `FSTR_ASSERT_NOW(a_forward_has_no_read, m_tvalid && m_tuser[0], m_tdata[7:0] == 8'h00)
  `FSTR_ASSERT_NEXT(a_one_item_in_flight, s_tvalid && s_tready, !s_tready)

endmodule

`default_nettype wire

/* hw/rtl/fstr_div.sv */
// ----------------------------------------------------------------------------
// fstr_div - radix-2 restoring divider
// One quotient bit per cycle over the dividend width; quotient holds
// after busy falls.
// ----------------------------------------------------------------------------
`default_nettype none

module fstr_div (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic [fstr_pkg::DIVIDEND_W-1:0]  dividend,
  input  wire logic [fstr_pkg::RATE_W-1:0]      divisor,
  output logic                                  busy,
  output logic [fstr_pkg::DIVIDEND_W-1:0]       quotient
);

  logic [fstr_pkg::RATE_W-1:0]    rem;
  logic [fstr_pkg::DIV_CNT_W-1:0] cnt;
  logic [fstr_pkg::RATE_W:0]      shifted;
  logic                           fits;

  // trial subtract
  assign shifted = {rem, quotient[fstr_pkg::DIVIDEND_W-1]};
  assign fits    = shifted >= {1'b0, divisor};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == '0) begin
      busy <= 1'b0;
    end
  end

  // iteration
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
      cnt      <= fstr_pkg::DIV_CNT_W'(fstr_pkg::DIVIDEND_W - 1);
    end else if (busy) begin
      if (fits) begin
        rem <= fstr_pkg::RATE_W'(shifted - {1'b0, divisor});
      end else begin
        rem <= shifted[fstr_pkg::RATE_W-1:0];
      end
      quotient <= {quotient[fstr_pkg::DIVIDEND_W-2:0], fits};
      cnt      <= cnt - 1'b1;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/fstr_datapath.sv */
// ----------------------------------------------------------------------------
// fstr_datapath - timer state, clock, arming arithmetic and output register
// Executes the commands of the controller; holds the address latch,
// the microsecond clock, both timers and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fstr_datapath (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire fstr_pkg::fstr_cmd_t             cmd,
  output fstr_pkg::fstr_stat_t                 stat,
  // item payload
  input  wire logic [fstr_pkg::S_TDATA_W-1:0]  s_tdata,
  input  wire logic [fstr_pkg::S_TUSER_W-1:0]  s_tuser,
  // rate registers
  input  wire logic [fstr_pkg::RATE_W-1:0]     rate_one,
  input  wire logic [fstr_pkg::RATE_W-1:0]     rate_two,
  // result
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [fstr_pkg::M_TDATA_W-1:0]       m_tdata,
  output logic [fstr_pkg::M_TUSER_W-1:0]       m_tuser
);

  // captured item
  logic [fstr_pkg::ACT_W-1:0]     act;
  logic [fstr_pkg::BYTE_W-1:0]    pdata;
  logic [fstr_pkg::ELAPSED_W-1:0] elapsed;

  // architectural state
  logic [fstr_pkg::REG_W-1:0]  addr_latch;
  fstr_pkg::time_t             clock_now;
  logic [fstr_pkg::BYTE_W-1:0] cnt_one;
  logic [fstr_pkg::BYTE_W-1:0] cnt_two;
  logic                        on_one;
  logic                        on_two;
  fstr_pkg::time_t             exp_one;
  fstr_pkg::time_t             exp_two;

  // arming
  logic                           pend_one;
  logic                           pend_two;
  logic                           sel_two;
  logic [fstr_pkg::DIVIDEND_W-1:0] prod;
  logic [fstr_pkg::RATE_W-1:0]    divisor;
  logic [fstr_pkg::DIVIDEND_W-1:0] quo;
  logic                           div_busy;

  // staged result
  logic [fstr_pkg::BYTE_W-1:0] res_read;
  logic                        res_fwd;
  logic [fstr_pkg::REG_W-1:0]  res_reg;
  logic [fstr_pkg::BYTE_W-1:0] res_val;

  // combinational helpers
  logic                         hit_one;
  logic                         hit_two;
  logic [fstr_pkg::BYTE_W-1:0]  status_byte;
  logic [fstr_pkg::BYTE_W-1:0]  sel_cnt;
  logic [fstr_pkg::RATE_W-1:0]  sel_rate;
  logic [fstr_pkg::TICKS_W-1:0] ticks;
  logic [fstr_pkg::PROD_W-1:0]  prod_full;
  logic [fstr_pkg::BYTE_W-1:0]  reg_low;
  logic                         is_data;
  logic                         ctl_run;
  logic                         arm_one;
  logic                         arm_two;
  logic                         fwd_hit;

  // status byte: strictly past expiry
  assign hit_one     = on_one && (clock_now > exp_one);
  assign hit_two     = on_two && (clock_now > exp_two);
  assign status_byte = (hit_one ? (fstr_pkg::STAT_ANY | fstr_pkg::STAT_ONE) : '0) |
                       (hit_two ? (fstr_pkg::STAT_ANY | fstr_pkg::STAT_TWO) : '0);

  // data write decode: rearm requests and forwarding
  assign reg_low = addr_latch[fstr_pkg::BYTE_W-1:0];
  assign is_data = (act == fstr_pkg::ACT_DATA);
  assign ctl_run = (reg_low == fstr_pkg::REG_TIMER_CTRL) && !pdata[fstr_pkg::CTL_STOP_BIT];
  assign arm_one = is_data &&
                   (((reg_low == fstr_pkg::REG_TIMER_ONE) && on_one) ||
                    (ctl_run && !pdata[fstr_pkg::CTL_MASK_ONE_BIT] &&
                     pdata[fstr_pkg::CTL_EN_ONE_BIT]));
  assign arm_two = is_data &&
                   (((reg_low == fstr_pkg::REG_TIMER_TWO) && on_two) ||
                    (ctl_run && !pdata[fstr_pkg::CTL_MASK_TWO_BIT] &&
                     pdata[fstr_pkg::CTL_EN_TWO_BIT]));
  assign fwd_hit = is_data &&
                   (reg_low != fstr_pkg::REG_TIMER_ONE) &&
                   (reg_low != fstr_pkg::REG_TIMER_TWO) &&
                   (reg_low != fstr_pkg::REG_TIMER_CTRL);

  // arm period numerator
  assign sel_cnt   = sel_two ? cnt_two : cnt_one;
  assign sel_rate  = sel_two ? rate_two : rate_one;
  assign ticks     = fstr_pkg::TICK_BASE - {1'b0, sel_cnt};
  assign prod_full = fstr_pkg::PROD_W'(ticks) * fstr_pkg::PROD_W'(fstr_pkg::US_PER_SEC);

  assign stat.arm_pend = pend_one || pend_two;
  assign stat.div_busy = div_busy;
  assign stat.out_busy = m_tvalid && !m_tready;

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act     <= s_tuser;
      pdata   <= s_tdata[fstr_pkg::BYTE_W-1:0];
      elapsed <= s_tdata[fstr_pkg::BYTE_W +: fstr_pkg::ELAPSED_W];
    end
  end

  // timer and address state
  always_ff @(posedge clk) begin
    if (rst) begin
      addr_latch <= '0;
      clock_now  <= '0;
      cnt_one    <= '0;
      cnt_two    <= '0;
      on_one     <= 1'b0;
      on_two     <= 1'b0;
      exp_one    <= '0;
      exp_two    <= '0;
      pend_one   <= 1'b0;
      pend_two   <= 1'b0;
    end else begin
      if (cmd.adv) begin
        clock_now <= clock_now + fstr_pkg::time_t'(elapsed);
      end
      if (cmd.apply) begin
        pend_one <= arm_one;
        pend_two <= arm_two;
        case (act)
          fstr_pkg::ACT_ADDR: begin
            addr_latch <= {1'b0, pdata};
          end
          fstr_pkg::ACT_ADDR_HI: begin
            addr_latch <= fstr_pkg::BANK_HI | {1'b0, pdata};
          end
          fstr_pkg::ACT_DATA: begin
            case (reg_low)
              fstr_pkg::REG_TIMER_ONE: begin
                cnt_one <= pdata;
              end
              fstr_pkg::REG_TIMER_TWO: begin
                cnt_two <= pdata;
              end
              fstr_pkg::REG_TIMER_CTRL: begin
                if (pdata[fstr_pkg::CTL_STOP_BIT]) begin
                  on_one <= 1'b0;
                  on_two <= 1'b0;
                end else begin
                  if (!pdata[fstr_pkg::CTL_MASK_ONE_BIT]) begin
                    on_one <= pdata[fstr_pkg::CTL_EN_ONE_BIT];
                  end
                  if (!pdata[fstr_pkg::CTL_MASK_TWO_BIT]) begin
                    on_two <= pdata[fstr_pkg::CTL_EN_TWO_BIT];
                  end
                end
              end
              default: begin
              end
            endcase
          end
          default: begin
          end
        endcase
      end
      // timer one goes first when both are pending
      if (cmd.pick) begin
        if (pend_one) begin
          pend_one <= 1'b0;
        end else begin
          pend_two <= 1'b0;
        end
      end
      if (cmd.finish) begin
        if (sel_two) begin
          exp_two <= clock_now + fstr_pkg::time_t'(quo);
        end else begin
          exp_one <= clock_now + fstr_pkg::time_t'(quo);
        end
      end
    end
  end

  // arming operands
  always_ff @(posedge clk) begin
    if (cmd.pick) begin
      sel_two <= !pend_one;
    end
    if (cmd.mul) begin
      prod    <= prod_full[fstr_pkg::DIVIDEND_W-1:0];
      divisor <= (sel_rate == '0) ? fstr_pkg::RATE_W'(1) : sel_rate;
    end
  end

  fstr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (prod),
    .divisor  (divisor),
    .busy     (div_busy),
    .quotient (quo)
  );

  // staged result
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      res_fwd <= fwd_hit;
      res_reg <= fwd_hit ? addr_latch : '0;
      res_val <= fwd_hit ? pdata : '0;
      case (act)
        fstr_pkg::ACT_STATUS: begin
          res_read <= status_byte;
        end
        fstr_pkg::ACT_READ_HI: begin
          res_read <= fstr_pkg::READ_HI_VAL;
        end
        default: begin
          res_read <= '0;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= fstr_pkg::M_TDATA_W'({res_val, res_reg, res_read});
      m_tuser <= res_fwd;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/fstr_ctrl.sv */
// ----------------------------------------------------------------------------
// fstr_ctrl - item sequencer
// Walks one item through clock advance, decode, up to two timer
// rearms and the hand-off to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fstr_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire fstr_pkg::fstr_stat_t stat,
  output fstr_pkg::fstr_cmd_t       cmd
);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_ADV   = 8'b0000_0010,
    ST_APPLY = 8'b0000_0100,
    ST_SEL   = 8'b0000_1000,
    ST_MUL   = 8'b0001_0000,
    ST_START = 8'b0010_0000,
    ST_DIV   = 8'b0100_0000,
    ST_EMIT  = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = (state == ST_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_ADV;
        end
      end
      ST_ADV: begin
        cmd.adv    = 1'b1;
        state_next = ST_APPLY;
      end
      ST_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = ST_SEL;
      end
      ST_SEL: begin
        if (stat.arm_pend) begin
          cmd.pick   = 1'b1;
          state_next = ST_MUL;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_START;
      end
      ST_START: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV;
      end
      ST_DIV: begin
        if (!stat.div_busy) begin
          cmd.finish = 1'b1;
          state_next = ST_SEL;
        end
      end
      ST_EMIT: begin
        if (!stat.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire
